@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file tcspq_chk of this project.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge while reset is released.
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// When the condition holds, the consequence must hold in the next cycle.
`define ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

@@ rtl/tcspq_pkg.sv @@
`default_nettype none

package tcspq_pkg;

	// One stored queue entry.
	typedef struct packed {
		logic [15:0] tag;
		logic [15:0] fuel;
		logic [7:0]  priority_val;
	} entry_t;

	// Request commands.
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_POP    = 1'b1;

	// Result status codes.
	localparam logic [1:0] ST_INSERTED = 2'd0;
	localparam logic [1:0] ST_POPPED   = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	// Priority value that marks an emergency entry.
	localparam logic [7:0] PRI_EMERGENCY = 8'd1;

endpackage

`default_nettype wire

@@ rtl/tcspq_mem.sv @@
`default_nettype none

module tcspq_mem #(
	parameter int DEPTH = 16
) (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [$clog2(DEPTH)-1:0]   waddr,
	input  wire tcspq_pkg::entry_t          wdata,
	input  wire logic                       re,
	input  wire logic [$clog2(DEPTH)-1:0]   raddr,
	output tcspq_pkg::entry_t               rdata
);
	import tcspq_pkg::*;

	entry_t mem_q [DEPTH];
	entry_t rdata_q;

	// Single write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Single read port with registered data.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ rtl/tcspq_cmp.sv @@
`default_nettype none

module tcspq_cmp (
	input  wire tcspq_pkg::entry_t  stored,
	input  wire logic [15:0]        new_fuel,
	input  wire logic [7:0]         new_priority,
	output logic                    goes_after
);
	import tcspq_pkg::*;

	logic stored_normal;
	logic new_normal;

	// Class rank: emergency entries rank before normal ones.
	assign stored_normal = (stored.priority_val != PRI_EMERGENCY);
	assign new_normal    = (new_priority != PRI_EMERGENCY);

	// The stored entry moves behind the new one when it ranks in a later class, or in
	// the same class with strictly larger fuel. Equal fuel keeps arrival order.
	assign goes_after = (stored_normal && !new_normal) ||
		((stored_normal == new_normal) && (stored.fuel > new_fuel));

endmodule

`default_nettype wire

@@ rtl/two_class_sorted_priority_queue.sv @@
`default_nettype none

// Sorted priority queue of up to CAPACITY entries, emergency entries (priority 1) first and
// then normal ones, each class in ascending fuel order with ties kept in arrival order. One
// request is handled at a time: in_ready is high only while the sequencer is idle, and the
// result waits in an output register, so a new request may be taken before it is collected.
// A pop goes through the pop-wait state to the response state; a pop while empty, an insert
// into a full queue and an insert into an empty queue go straight to it. An insert into a
// non-empty queue walks backwards from the tail through the entry memory, one entry a cycle,
// using its single read port and one shared compare unit. The result becomes valid in the
// same cycle as in_ready rises again, and the last step of a request waits for as long as
// an earlier result is still held uncollected in the output register. The stored entries
// live in a circular buffer, so a pop only advances the head pointer. The entries need no
// clearing after reset.

module two_class_sorted_priority_queue #(
	parameter int CAPACITY = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        command,
	input  wire logic [15:0] tag,
	input  wire logic [15:0] fuel,
	input  wire logic [7:0]  priority_req,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic [15:0]      out_tag,
	output logic [15:0]      out_fuel,
	output logic [7:0]       out_priority,
	output logic [4:0]       occupancy
);
	import tcspq_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CMP,
		S_PLACE,
		S_POP_WAIT,
		S_RESP
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   count_q;
	logic [AW-1:0]   head_q;
	logic [AW-1:0]   k_q;
	entry_t          new_q;
	logic [1:0]      res_status_q;
	entry_t          res_entry_q;
	logic            out_valid_q;
	logic [1:0]      out_status_q;
	entry_t          out_entry_q;
	logic [4:0]      out_occ_q;

	entry_t          in_entry;
	entry_t          rd_data;
	entry_t          mem_wdata;
	logic            mem_we;
	logic            mem_re;
	logic [AW-1:0]   wr_k;
	logic [AW-1:0]   rd_k;
	logic            goes_after;
	logic            is_full;
	logic            is_empty;

	// Map a position in queue order to its slot in the circular buffer.
	function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] hd, input logic [AW-1:0] k);
		logic [AW:0] s;
		s = {1'b0, hd} + {1'b0, k};
		if (s >= (AW + 1)'(CAPACITY)) begin
			s = s - (AW + 1)'(CAPACITY);
		end
		return s[AW-1:0];
	endfunction

	assign in_entry.tag          = tag;
	assign in_entry.fuel         = fuel;
	assign in_entry.priority_val = priority_req;

	assign is_full  = (count_q == CW'(CAPACITY));
	assign is_empty = (count_q == '0);
	assign in_ready = (state_q == S_IDLE);

	tcspq_mem #(
		.DEPTH(CAPACITY)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (slot_of(head_q, wr_k)),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (slot_of(head_q, rd_k)),
		.rdata (rd_data)
	);

	tcspq_cmp u_cmp (
		.stored       (rd_data),
		.new_fuel     (new_q.fuel),
		.new_priority (new_q.priority_val),
		.goes_after   (goes_after)
	);

	// Memory port control for each step of the sequencer.
	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		wr_k      = '0;
		rd_k      = '0;
		mem_wdata = new_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (command == CMD_INSERT) begin
						if (!is_full && is_empty) begin
							mem_we    = 1'b1;
							mem_wdata = in_entry;
						end else if (!is_full) begin
							mem_re = 1'b1;
							rd_k   = AW'(count_q - CW'(1));
						end
					end else if (!is_empty) begin
						mem_re = 1'b1;
					end
				end
			end
			S_CMP: begin
				mem_we = 1'b1;
				wr_k   = k_q;
				if (goes_after) begin
					mem_wdata = rd_data;
					if (k_q != AW'(1)) begin
						mem_re = 1'b1;
						rd_k   = (k_q - AW'(1)) - AW'(1);
					end
				end
			end
			S_PLACE: begin
				mem_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Sequencer with its registered results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			head_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A collected result frees the output register unless a new one is loaded now.
			if (out_valid_q && out_ready && (state_q != S_RESP)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						new_q       <= in_entry;
						res_entry_q <= '0;
						if (command == CMD_INSERT) begin
							if (is_full) begin
								res_status_q <= ST_FULL;
								state_q      <= S_RESP;
							end else if (is_empty) begin
								count_q      <= count_q + CW'(1);
								res_status_q <= ST_INSERTED;
								state_q      <= S_RESP;
							end else begin
								k_q     <= AW'(count_q);
								state_q <= S_CMP;
							end
						end else begin
							if (is_empty) begin
								res_status_q <= ST_EMPTY;
								state_q      <= S_RESP;
							end else begin
								state_q <= S_POP_WAIT;
							end
						end
					end
				end
				S_CMP: begin
					if (goes_after) begin
						k_q <= k_q - AW'(1);
						if (k_q == AW'(1)) begin
							state_q <= S_PLACE;
						end
					end else begin
						count_q      <= count_q + CW'(1);
						res_status_q <= ST_INSERTED;
						state_q      <= S_RESP;
					end
				end
				S_PLACE: begin
					count_q      <= count_q + CW'(1);
					res_status_q <= ST_INSERTED;
					state_q      <= S_RESP;
				end
				S_POP_WAIT: begin
					res_entry_q  <= rd_data;
					res_status_q <= ST_POPPED;
					head_q       <= slot_of(head_q, AW'(1));
					count_q      <= count_q - CW'(1);
					state_q      <= S_RESP;
				end
				S_RESP: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_entry_q  <= res_entry_q;
						out_occ_q    <= 5'(count_q);
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign out_tag      = out_entry_q.tag;
	assign out_fuel     = out_entry_q.fuel;
	assign out_priority = out_entry_q.priority_val;
	assign occupancy    = out_occ_q;

endmodule

`default_nettype wire

@@ rtl/tcspq_chk.sv @@
`default_nettype none

`include "assert_macros.svh"

module tcspq_chk #(
	parameter int CAPACITY = 16
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        command,
	input wire logic [15:0] tag,
	input wire logic [15:0] fuel,
	input wire logic [7:0]  priority_req,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [1:0]  status,
	input wire logic [15:0] out_tag,
	input wire logic [15:0] out_fuel,
	input wire logic [7:0]  out_priority,
	input wire logic [4:0]  occupancy
);
	import tcspq_pkg::*;

	logic in_fire;
	logic non_pop_result;

	assign in_fire        = in_valid && in_ready;
	assign non_pop_result = out_valid && (status != ST_POPPED);

	// A waiting result keeps its status and occupancy until it is collected.
	`ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(occupancy), "result changed while stalled")

	// Only a pop carries entry fields.
	`ASSERT_ALWAYS(a_zero_fields, !non_pop_result || (out_tag == '0 && out_fuel == '0 && out_priority == '0), "non-pop result carries entry fields")

	// A pop while empty reports an empty queue.
	`ASSERT_ALWAYS(a_empty_occ, !(out_valid && status == ST_EMPTY) || (occupancy == '0), "empty pop with nonzero occupancy")

	// A dropped insert reports a full queue.
	`ASSERT_ALWAYS(a_full_occ, !(out_valid && status == ST_FULL) || (occupancy == 5'(CAPACITY)), "dropped insert while not full")

	// The block takes one request at a time.
	`ASSERT_NEXT(a_busy, in_fire, !in_ready, "request taken while busy")

endmodule

bind two_class_sorted_priority_queue tcspq_chk #(.CAPACITY(CAPACITY)) u_tcspq_chk (.*);

`default_nettype wire

@@ bench/queue_order_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels of the priority queue, keeps a shadow copy of the
// ordered entries and checks every result against the predicted outcome.
module queue_order_checker #(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        command,
	input  logic [15:0] tag,
	input  logic [15:0] fuel,
	input  logic [7:0]  priority_req,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  status,
	input  logic [15:0] out_tag,
	input  logic [15:0] out_fuel,
	input  logic [7:0]  out_priority,
	input  logic [4:0]  occupancy,
	output int          fail_count,
	output int          pending,
	output int          full_drops,
	output int          empty_pops
);
	import tcspq_pkg::*;

	// One predicted outcome of a request.
	typedef struct {
		logic [1:0]  status;
		logic [15:0] tag;
		logic [15:0] fuel;
		logic [7:0]  prio;
		logic [4:0]  occupancy;
	} outcome_t;

	entry_t   shadow_entries [CAPACITY];
	int       shadow_count = 0;
	outcome_t awaited_outcomes [$];

	initial begin
		fail_count = 0;
		pending    = 0;
		full_drops = 0;
		empty_pops = 0;
	end

	// Prints one line per mismatch and counts it.
	task automatic report_mismatch(input string what);
		$display("[%0t] MISMATCH: %s", $time, what);
		fail_count++;
	endtask

	function automatic bit is_emergency(input logic [7:0] p);
		return p == PRI_EMERGENCY;
	endfunction

	// Applies one accepted request to the shadow queue and records its outcome.
	task automatic apply_request(input logic cmd, input logic [15:0] t, input logic [15:0] f,
			input logic [7:0] p);
		outcome_t o;
		int       pos;
		bit       goes_after;
		o = '{default: '0};
		if (cmd == CMD_INSERT) begin
			if (shadow_count >= CAPACITY) begin
				o.status = ST_FULL;
				full_drops++;
			end else begin
				// The new entry goes behind every entry of an earlier class and behind
				// every entry of its own class whose fuel is not greater than its own.
				pos = 0;
				goes_after = 1'b1;
				while (pos < shadow_count && goes_after) begin
					if (is_emergency(shadow_entries[pos].priority_val) && !is_emergency(p))
						goes_after = 1'b1;
					else if (is_emergency(shadow_entries[pos].priority_val) == is_emergency(p))
						goes_after = shadow_entries[pos].fuel <= f;
					else
						goes_after = 1'b0;
					if (goes_after)
						pos++;
				end
				for (int i = shadow_count; i > pos; i--)
					shadow_entries[i] = shadow_entries[i - 1];
				shadow_entries[pos] = '{tag: t, fuel: f, priority_val: p};
				shadow_count++;
				o.status = ST_INSERTED;
			end
		end else begin
			if (shadow_count == 0) begin
				o.status = ST_EMPTY;
				empty_pops++;
			end else begin
				o.tag  = shadow_entries[0].tag;
				o.fuel = shadow_entries[0].fuel;
				o.prio = shadow_entries[0].priority_val;
				for (int i = 0; i < shadow_count - 1; i++)
					shadow_entries[i] = shadow_entries[i + 1];
				shadow_count--;
				o.status = ST_POPPED;
			end
		end
		o.occupancy = shadow_count[4:0];
		awaited_outcomes.push_back(o);
	endtask

	// Compares one collected result with the oldest outstanding outcome.
	task automatic check_result();
		outcome_t o;
		if (awaited_outcomes.size() == 0) begin
			report_mismatch($sformatf("result with status %0d but no request outstanding",
					status));
		end else begin
			o = awaited_outcomes.pop_front();
			if (status !== o.status)
				report_mismatch($sformatf("status got %0d want %0d", status, o.status));
			if (out_tag !== o.tag)
				report_mismatch($sformatf("out_tag got %h want %h", out_tag, o.tag));
			if (out_fuel !== o.fuel)
				report_mismatch($sformatf("out_fuel got %h want %h", out_fuel, o.fuel));
			if (out_priority !== o.prio)
				report_mismatch($sformatf("out_priority got %h want %h", out_priority, o.prio));
			if (occupancy !== o.occupancy)
				report_mismatch($sformatf("occupancy got %0d want %0d", occupancy,
						o.occupancy));
		end
	endtask

	// Both channels are sampled at the rising edge.
	always @(posedge clk) begin
		if (!arst_n) begin
			shadow_count = 0;
			awaited_outcomes.delete();
		end else begin
			if (out_valid && out_ready)
				check_result();
			if (in_valid && in_ready)
				apply_request(command, tag, fuel, priority_req);
		end
		pending = awaited_outcomes.size();
	end

endmodule

@@ bench/two_class_sorted_priority_queue_tb.sv @@
`timescale 1ns / 1ps

module two_class_sorted_priority_queue_tb;
	import tcspq_pkg::*;

	localparam int CAPACITY    = 16;
	localparam int N_REQUESTS  = 1850;
	localparam int IDLE_LIMIT  = 4000;
	localparam int LONG_HOLD   = 300;
	localparam int TAIL_CYCLES = 40;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        command;
	logic [15:0] tag;
	logic [15:0] fuel;
	logic [7:0]  priority_req;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;
	logic [15:0] out_tag;
	logic [15:0] out_fuel;
	logic [7:0]  out_priority;
	logic [4:0]  occupancy;

	int fail_count;
	int pending;
	int full_drops;
	int empty_pops;
	int requests_sent = 0;
	int idle_cycles   = 0;
	bit drained_once  = 1'b0;

	two_class_sorted_priority_queue #(
		.CAPACITY(CAPACITY)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.tag(tag),
		.fuel(fuel),
		.priority_req(priority_req),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.out_tag(out_tag),
		.out_fuel(out_fuel),
		.out_priority(out_priority),
		.occupancy(occupancy)
	);

	queue_order_checker #(
		.CAPACITY(CAPACITY)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.tag(tag),
		.fuel(fuel),
		.priority_req(priority_req),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.out_tag(out_tag),
		.out_fuel(out_fuel),
		.out_priority(out_priority),
		.occupancy(occupancy),
		.fail_count(fail_count),
		.pending(pending),
		.full_drops(full_drops),
		.empty_pops(empty_pops)
	);

	// Clock with a 2 ns period.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Offers one request from the falling edge and holds it until accepted.
	task automatic send_request(input logic cmd, input logic [15:0] t, input logic [15:0] f,
			input logic [7:0] p);
		@(negedge clk);
		in_valid     <= 1'b1;
		command      <= cmd;
		tag          <= t;
		fuel         <= f;
		priority_req <= p;
		do @(posedge clk); while (!in_ready);
		requests_sent++;
	endtask

	// Random request; fuel is often narrow so that ties occur, and half are emergencies.
	task automatic send_random(input int pop_pct);
		logic        cmd;
		logic [15:0] f;
		logic [7:0]  p;
		cmd = ($urandom_range(0, 99) < pop_pct) ? CMD_POP : CMD_INSERT;
		case ($urandom_range(0, 3))
			0: f = 16'($urandom_range(0, 7));
			1: f = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			default: f = 16'($urandom);
		endcase
		p = $urandom_range(0, 1) ? PRI_EMERGENCY : 8'($urandom);
		send_request(cmd, 16'($urandom), f, p);
	endtask

	// Drops valid and idles the sender for a number of cycles.
	task automatic idle_sender(input int gap);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (gap) @(negedge clk);
	endtask

	// Receiver: changing stall patterns, plus one long hold-off that fills the block.
	initial begin
		int  hold_left;
		int  phase_left;
		int  stall_mode;
		bit  held_long;
		hold_left  = 0;
		phase_left = 0;
		stall_mode = 0;
		held_long  = 1'b0;
		out_ready  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (!held_long && requests_sent >= 700) begin
				held_long = 1'b1;
				hold_left = LONG_HOLD - 1;
				out_ready <= 1'b0;
			end else begin
				if (phase_left == 0) begin
					stall_mode = $urandom_range(0, 3);
					phase_left = $urandom_range(20, 200);
				end
				phase_left--;
				case (stall_mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 3) != 0);
					2: out_ready <= 1'($urandom_range(0, 1));
					default: out_ready <= ((phase_left % 5) < 2);
				endcase
			end
		end
	end

	// Watchdog: ends the run when nothing is accepted for too long.
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Watchdog expired after %0d cycles without a handshake", idle_cycles);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// Stimulus and verdict.
	initial begin
		int burst_len;
		int pop_pct;
		in_valid     = 1'b0;
		command      = CMD_INSERT;
		tag          = '0;
		fuel         = '0;
		priority_req = '0;
		arst_n       = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: empty pop, field extremes, fuel ties in both classes, full queue.
		send_request(CMD_POP, 16'h0000, 16'h0000, 8'h00);
		send_request(CMD_INSERT, 16'h0000, 16'hFFFF, 8'h00);
		send_request(CMD_INSERT, 16'hFFFF, 16'h0000, 8'hFF);
		send_request(CMD_INSERT, 16'h1234, 16'd100, PRI_EMERGENCY);
		send_request(CMD_INSERT, 16'hABCD, 16'd100, PRI_EMERGENCY);
		send_request(CMD_INSERT, 16'h0005, 16'd100, 8'h02);
		send_request(CMD_INSERT, 16'h0006, 16'd100, 8'h00);
		send_request(CMD_INSERT, 16'h0007, 16'h0000, PRI_EMERGENCY);
		send_request(CMD_INSERT, 16'h0008, 16'hFFFF, PRI_EMERGENCY);
		send_request(CMD_INSERT, 16'h0009, 16'd50, 8'hFE);
		for (int i = 0; i < 7; i++)
			send_random(0);
		send_request(CMD_INSERT, 16'hFFFF, 16'hFFFF, PRI_EMERGENCY);
		for (int i = 0; i < 7; i++)
			send_request(CMD_POP, 16'hFFFF, 16'hFFFF, 8'hFF);
		idle_sender(5);

		// Random part: bursts that mostly fill, mostly drain or mix.
		while (requests_sent < N_REQUESTS) begin
			burst_len = $urandom_range(1, 40);
			case ($urandom_range(0, 2))
				0: pop_pct = 15;
				1: pop_pct = 85;
				default: pop_pct = 50;
			endcase
			for (int i = 0; i < burst_len && requests_sent < N_REQUESTS; i++)
				send_random(pop_pct);
			idle_sender(($urandom_range(0, 3) == 0) ? $urandom_range(5, 30) :
					$urandom_range(0, 3));
			// Once in the run, let every outstanding result come back before going on.
			if (!drained_once && requests_sent >= 1200) begin
				drained_once = 1'b1;
				wait (pending == 0);
			end
		end

		wait (pending == 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Covered %0d requests, with %0d inserts into a full queue and %0d pops",
				requests_sent, full_drops, empty_pops);
		$display("of an empty queue, one long output hold-off and one full drain.");
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/tcspq_pkg.sv
rtl/tcspq_mem.sv
rtl/tcspq_cmp.sv
rtl/two_class_sorted_priority_queue.sv
rtl/tcspq_chk.sv
bench/queue_order_checker.sv
bench/two_class_sorted_priority_queue_tb.sv
